FILE: design/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared constants, codes and controller/datapath types for the nearest
// colour search block.
// ----------------------------------------------------------------------------
package ncs_pkg;

   // Store geometry
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // Field widths
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int INDEX_W  = 10;
   localparam int LB_W     = 11;
   localparam int POS_W    = 10;
   localparam int DIST_W   = 10;
   localparam int ENTRY_W  = 11;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic write;   // store the incoming entry
      logic start;   // latch query and set up scan
      logic step;    // issue one store read and advance
      logic finish;  // move the best match into the result register
   } ncs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_more;  // entries left in the search range
      logic out_free;   // result register can take a new transaction
   } ncs_status_type;

   // Absolute difference of two colour channels
   function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

endpackage

FILE: design/ncs_ctrl.sv
// ----------------------------------------------------------------------------
// ncs_ctrl
// Sequencer for the nearest colour search: takes requests, walks the scan
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module ncs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   input  ncs_pkg::ncs_status_type status,
   output ncs_pkg::ncs_cmd_type    cmd
);
   import ncs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Decode next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_more) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/ncs_datapath.sv
// ----------------------------------------------------------------------------
// ncs_datapath
// Pixel store, scan counter, L1 distance unit, best-match tracker and the
// result register.
// ----------------------------------------------------------------------------
module ncs_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ncs_pkg::ncs_cmd_type                 cmd,
   output ncs_pkg::ncs_status_type              status,
   input  logic [ncs_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic [ncs_pkg::CHAN_W-1:0]           req_red,
   input  logic [ncs_pkg::CHAN_W-1:0]           req_green,
   input  logic [ncs_pkg::CHAN_W-1:0]           req_blue,
   input  logic signed [ncs_pkg::LB_W-1:0]      req_lower_bound,
   input  logic [ncs_pkg::ENTRY_W-1:0]          entries_in_use,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ncs_pkg::POS_W-1:0]            rsp_position,
   output logic [ncs_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                 rsp_found
);
   import ncs_pkg::*;

   // Pixel store
   logic [PIX_W-1:0] mem [STORE_DEPTH];

   logic [31:0]       idx_wide;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   // Scan range
   logic signed [LB_W:0] start_s;
   logic [31:0]          start_wide;
   logic [CNT_W-1:0]     start_cnt;
   logic [31:0]          end_wide;
   logic [CNT_W-1:0]     end_cnt;

   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CHAN_W-1:0] tgt_r_ff, tgt_r_in;
   logic [CHAN_W-1:0] tgt_g_ff, tgt_g_in;
   logic [CHAN_W-1:0] tgt_b_ff, tgt_b_in;

   // Read stage
   logic [PIX_W-1:0]  rd_data_ff;
   logic              rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] rd_pos_ff, rd_pos_in;

   // Distance and best match
   logic [DIST_W-1:0] l1_dist;
   logic              better;
   logic              found_ff, found_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [ADDR_W-1:0] best_pos_ff, best_pos_in;
   logic [31:0]       best_pos_wide;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_found_ff, rsp_found_in;

   // Drop writes beyond the store
   always_comb begin
      idx_wide = 32'(req_entry_index);
      wr_en    = cmd.write && (idx_wide < 32'(STORE_DEPTH));
      wr_addr  = idx_wide[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_red, req_green, req_blue};
      end
   end

   // Registered store read
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rd_data_ff <= mem[scan_ff[ADDR_W-1:0]];
      end
   end

   // Work out the scan range: start after the lower bound, stop at the count
   always_comb begin
      start_s    = (LB_W+1)'(req_lower_bound) + (LB_W+1)'(1);
      start_wide = 32'(start_s[LB_W-1:0]);
      if (start_s[LB_W]) begin
         start_cnt = '0;
      end else if (start_wide > 32'(STORE_DEPTH)) begin
         start_cnt = CNT_W'(STORE_DEPTH);
      end else begin
         start_cnt = CNT_W'(start_wide);
      end
      end_wide = 32'(entries_in_use);
      if (end_wide > 32'(STORE_DEPTH)) begin
         end_cnt = CNT_W'(STORE_DEPTH);
      end else begin
         end_cnt = CNT_W'(end_wide);
      end
   end

   // Advance the scan counter
   always_comb begin
      scan_in   = scan_ff;
      end_in    = end_ff;
      tgt_r_in  = tgt_r_ff;
      tgt_g_in  = tgt_g_ff;
      tgt_b_in  = tgt_b_ff;
      rd_vld_in = cmd.step;
      rd_pos_in = rd_pos_ff;
      if (cmd.start) begin
         scan_in  = start_cnt;
         end_in   = end_cnt;
         tgt_r_in = req_red;
         tgt_g_in = req_green;
         tgt_b_in = req_blue;
      end else if (cmd.step) begin
         scan_in   = scan_ff + CNT_W'(1);
         rd_pos_in = scan_ff[ADDR_W-1:0];
      end
   end

   // L1 distance of the entry just read; strict compare keeps the lowest index
   always_comb begin
      l1_dist = DIST_W'(chan_diff(tgt_r_ff, rd_data_ff[PIX_W-1:2*CHAN_W]))
              + DIST_W'(chan_diff(tgt_g_ff, rd_data_ff[2*CHAN_W-1:CHAN_W]))
              + DIST_W'(chan_diff(tgt_b_ff, rd_data_ff[CHAN_W-1:0]));
      better = rd_vld_ff && (!found_ff || (l1_dist < best_dist_ff));

      found_in     = found_ff;
      best_dist_in = best_dist_ff;
      best_pos_in  = best_pos_ff;
      if (cmd.start) begin
         found_in     = 1'b0;
         best_dist_in = '0;
         best_pos_in  = '0;
      end else if (better) begin
         found_in     = 1'b1;
         best_dist_in = l1_dist;
         best_pos_in  = rd_pos_ff;
      end
   end

   // Load the result register, clear it once the transaction is taken
   always_comb begin
      best_pos_wide = 32'(best_pos_ff);
      rsp_pos_in    = rsp_pos_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_found_in  = rsp_found_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = best_pos_wide[POS_W-1:0];
         rsp_dist_in  = best_dist_ff;
         rsp_found_in = found_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      end_ff       <= end_in;
      tgt_r_ff     <= tgt_r_in;
      tgt_g_ff     <= tgt_g_in;
      tgt_b_ff     <= tgt_b_in;
      rd_pos_ff    <= rd_pos_in;
      best_dist_ff <= best_dist_in;
      best_pos_ff  <= best_pos_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign status.scan_more = (scan_ff < end_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

FILE: design/nearest_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_color_search_top
// Pixel store with an L1 nearest-colour search over a range of entries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): op=0 writes {red,green,blue} to entry_index and
//   gives no response; op=1 searches entries lower_bound+1 .. entries_in_use-1
//   for the colour nearest to {red,green,blue} and gives one response.
//   Response channel (rsp_*): position and distance of the first entry with
//   the smallest sum of channel differences; found=0 (position and distance
//   zero) when the range is empty.
//   CSR port (csr_*): register 0 at byte address 0 holds entries_in_use.
// Timing:
//   Write transactions may follow back to back.
//   A search of N entries reads the store once per cycle through its single
//   read port; the response is then loaded once the output register is free,
//   and the next request is taken the cycle after it is loaded.
//   The response sits in an output register, so a new request is accepted
//   while the previous response still waits for rsp_ready. A second search
//   finishing before that response is taken holds until it leaves.
// Reset:
//   Clears the sequencer, the response valid and entries_in_use. Store
//   contents are undefined until written; no clearing pass is run.
// ----------------------------------------------------------------------------
module nearest_color_search_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [ncs_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic [ncs_pkg::CHAN_W-1:0]           req_red,
   input  logic [ncs_pkg::CHAN_W-1:0]           req_green,
   input  logic [ncs_pkg::CHAN_W-1:0]           req_blue,
   input  logic signed [ncs_pkg::LB_W-1:0]      req_lower_bound,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ncs_pkg::POS_W-1:0]            rsp_position,
   output logic [ncs_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                 rsp_found,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ncs_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ncs_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ncs_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import ncs_pkg::*;

   logic                  csr_index;
   logic                  csr_wr;
   logic [ENTRY_W-1:0]    entries_ff, entries_in;
   ncs_cmd_type           cmd;
   ncs_status_type        status;

   // Decode the register index from the byte address
   assign csr_index  = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      entries_in = entries_ff;
      if (csr_wr && (csr_index == REG_ENTRIES_IN_USE)) begin
         entries_in = csr_pwdata[ENTRY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

   // Return the register value on reads
   always_comb begin
      if (csr_index == REG_ENTRIES_IN_USE) begin
         csr_prdata = CSR_DATA_W'(entries_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   ncs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ncs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_lower_bound (req_lower_bound),
      .entries_in_use  (entries_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_distance    (rsp_distance),
      .rsp_found       (rsp_found)
   );

endmodule

FILE: design/ncs_checker.sv
// ----------------------------------------------------------------------------
// ncs_checker
// Port-level checks for the nearest colour search, bound to the top level.
// ----------------------------------------------------------------------------
module ncs_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [ncs_pkg::POS_W-1:0]            rsp_position,
   input  logic [ncs_pkg::DIST_W-1:0]           rsp_distance,
   input  logic                                 rsp_found
);
   import ncs_pkg::*;

   // No response is pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_position) && $stable(rsp_distance) && $stable(rsp_found))
      else $error("response payload changed while stalled");

   // An empty search reports zero position and distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_position == '0) && (rsp_distance == '0))
      else $error("empty search with non-zero fields");

   // Distance never exceeds the three-channel maximum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance <= DIST_W'(3 * 255)))
      else $error("distance out of range");

endmodule

bind nearest_color_search_top ncs_checker u_ncs_checker (.*);
